>>> rtl/ber_pkg.sv
// Shared types and constants of the bilinear embedding resampler.
// Field widths, register indexes, command codes and the result record.
// Depends on nothing.
package ber_pkg;

  localparam int POS_W      = 8;
  localparam int GRID_W     = 9;
  localparam int SIDE_W     = 6;
  localparam int DIM_W      = 6;
  localparam int WORD_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam int DIV_CYCLES = 3;
  localparam int RES_DEPTH  = 4;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE = 2'd2;

  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_OOR    = 2'd2;

  typedef struct packed {
    logic signed [WORD_W-1:0] sample;
    logic                     oor;
  } result_t;

endpackage

>>> rtl/bilinear_embedding_resample.sv
// Top level of the bilinear embedding resampler: table memory, position
// divider, read sequencer, weighting pipeline and result queue.
// Depends on ber_pkg.
//
// Usage: the request channel (in_valid_i / in_ready_o) carries loads, which
// write one table element and give no result, and samples, which give one
// interpolated element on the result channel (out_valid_o / out_ready_i).
// Configuration is written through cfg_we_i, cfg_index_i and cfg_data_i while
// the block is idle; reset sets a 1 x 1 output grid and a table side of 32.
// The table itself is not cleared and must be loaded before it is sampled.
// A sample passes through the position divider, which takes several quotient
// bits per cycle, and then reads its corners from the single-port table, one
// corner per cycle. Both steps overlap across requests: a new sample can
// enter the divider while the one before it reads its corners, and loads are
// taken every cycle while no earlier sample holds the divider or sequencer.
// Results wait in a four-entry queue; while the receiver stalls, up to four
// samples may be past the divider; one more waits in it and requests stall.
module bilinear_embedding_resample #(
  parameter int SIDE_LIMIT = 32,
  parameter int DIM        = 64,
  parameter int FRAC_BITS  = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ber_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ber_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               cmd_i,
  input  logic [ber_pkg::POS_W-1:0]          row_i,
  input  logic [ber_pkg::POS_W-1:0]          col_i,
  input  logic [ber_pkg::DIM_W-1:0]          dim_i,
  input  logic signed [ber_pkg::WORD_W-1:0]  word_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [ber_pkg::WORD_W-1:0]  sample_o,
  output logic                               out_of_range_o
);

  localparam int F      = FRAC_BITS;
  localparam int SEW    = $clog2(SIDE_LIMIT + 1);
  localparam int SW1    = $clog2(SIDE_LIMIT);
  localparam int DW     = ber_pkg::GRID_W;
  localparam int DC     = ber_pkg::DIV_CYCLES;
  localparam int QW     = SW1 + F;
  localparam int STEPS  = (QW + DC - 1) / DC;
  localparam int QP     = STEPS * DC;
  localparam int NW     = ber_pkg::POS_W + SW1 + F;
  localparam int IW     = $clog2(DC + 1);
  localparam int WW     = F + 1;
  localparam int WORDW  = ber_pkg::WORD_W;
  localparam int PRW    = 2 * WW + WORDW;
  localparam int DEPTH  = SIDE_LIMIT * SIDE_LIMIT * DIM;
  localparam int AW     = $clog2(DEPTH);
  localparam int RD     = ber_pkg::RES_DEPTH;
  localparam int RPW    = $clog2(RD);
  localparam int RCW    = $clog2(RD + 1);
  localparam int QIW    = QP - F;
  localparam int SATW   = PRW - 2 * F;

  // Configuration registers.
  logic [ber_pkg::GRID_W-1:0] rows_q, cols_q;
  logic [ber_pkg::SIDE_W-1:0] side_q;
  logic [SEW-1:0]             side_eff;
  logic [SW1-1:0]             sm1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ber_pkg::GRID_W'(1);
      cols_q <= ber_pkg::GRID_W'(1);
      side_q <= ber_pkg::SIDE_W'(32);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ber_pkg::CFG_ROWS: rows_q <= cfg_data_i;
        ber_pkg::CFG_COLS: cols_q <= cfg_data_i;
        ber_pkg::CFG_SIDE: side_q <= cfg_data_i[ber_pkg::SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (side_q == '0) begin
      side_eff = SEW'(1);
    end else if (32'(side_q) > SIDE_LIMIT) begin
      side_eff = SEW'(SIDE_LIMIT);
    end else begin
      side_eff = SEW'(side_q);
    end
    sm1 = SW1'(side_eff - SEW'(1));
  end

  function automatic logic [DW-1:0] den_of(input logic [DW-1:0] grid);
    return (grid > DW'(1)) ? DW'(grid - DW'(1)) : DW'(1);
  endfunction

  function automatic logic [NW-1:0] num_of(input logic [ber_pkg::POS_W-1:0] p,
                                           input logic [DW-1:0] den,
                                           input logic [SW1-1:0] s);
    return ((NW'(p) * NW'(s)) << F) + NW'(den >> 1);
  endfunction

  // Stage 1: request register and position divider.
  logic                        s1_valid_q;
  logic [1:0]                  s1_kind_q;
  logic [ber_pkg::POS_W-1:0]   s1_row_q, s1_col_q;
  logic [ber_pkg::DIM_W-1:0]   s1_dim_q;
  logic signed [WORDW-1:0]     s1_word_q;
  logic                        s1_ok_q;
  logic [IW-1:0]               iter_q;
  logic [DW-1:0]               den_h_q, den_w_q, rem_h_q, rem_w_q;
  logic [QP-1:0]               bits_h_q, bits_w_q;

  logic [DW-1:0]  den_h, den_w, rem_h_d, rem_w_d;
  logic [NW-1:0]  num_h, num_w;
  logic [QP-1:0]  bits_h_d, bits_w_d;
  logic [DW:0]    remx_h, remx_w;
  logic           s1_oor, s1_done, handoff, in_take;

  logic           s2_valid_q, s2_last, s2_open;
  logic [RCW-1:0] credit_q;

  assign den_h  = den_of(rows_q);
  assign den_w  = den_of(cols_q);
  assign num_h  = num_of(row_i, den_h, sm1);
  assign num_w  = num_of(col_i, den_w, sm1);
  assign s1_oor = (DW'(row_i) >= rows_q) || (DW'(col_i) >= cols_q) || (32'(dim_i) >= DIM);

  assign s1_done = s1_valid_q && ((s1_kind_q != ber_pkg::KIND_SAMPLE) || (iter_q == IW'(DC)));
  assign handoff = s1_done && s2_open &&
                   ((s1_kind_q == ber_pkg::KIND_LOAD) || (credit_q < RCW'(RD)));
  assign in_ready_o = !s1_valid_q || handoff;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    rem_h_d  = rem_h_q;
    rem_w_d  = rem_w_q;
    bits_h_d = bits_h_q;
    bits_w_d = bits_w_q;
    remx_h   = '0;
    remx_w   = '0;
    for (int i = 0; i < STEPS; i++) begin
      remx_h = {rem_h_d, bits_h_d[QP-1]};
      remx_w = {rem_w_d, bits_w_d[QP-1]};
      if (remx_h >= {1'b0, den_h_q}) begin
        rem_h_d  = DW'(remx_h - {1'b0, den_h_q});
        bits_h_d = {bits_h_d[QP-2:0], 1'b1};
      end else begin
        rem_h_d  = remx_h[DW-1:0];
        bits_h_d = {bits_h_d[QP-2:0], 1'b0};
      end
      if (remx_w >= {1'b0, den_w_q}) begin
        rem_w_d  = DW'(remx_w - {1'b0, den_w_q});
        bits_w_d = {bits_w_d[QP-2:0], 1'b1};
      end else begin
        rem_w_d  = remx_w[DW-1:0];
        bits_w_d = {bits_w_d[QP-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_kind_q  <= ber_pkg::KIND_LOAD;
      iter_q     <= '0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
      iter_q     <= '0;
      if (cmd_i == ber_pkg::CMD_LOAD) begin
        s1_kind_q <= ber_pkg::KIND_LOAD;
      end else if (s1_oor) begin
        s1_kind_q <= ber_pkg::KIND_OOR;
      end else begin
        s1_kind_q <= ber_pkg::KIND_SAMPLE;
      end
    end else begin
      if (handoff) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_valid_q && !s1_done) begin
        iter_q <= iter_q + IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_row_q  <= row_i;
      s1_col_q  <= col_i;
      s1_dim_q  <= dim_i;
      s1_word_q <= word_i;
      s1_ok_q   <= (32'(row_i) < 32'(side_eff)) && (32'(col_i) < 32'(side_eff)) &&
                   (32'(dim_i) < DIM);
      den_h_q   <= den_h;
      den_w_q   <= den_w;
      rem_h_q   <= DW'(num_h >> QP);
      rem_w_q   <= DW'(num_w >> QP);
      bits_h_q  <= num_h[QP-1:0];
      bits_w_q  <= num_w[QP-1:0];
    end else if (s1_valid_q && !s1_done) begin
      rem_h_q   <= rem_h_d;
      rem_w_q   <= rem_w_d;
      bits_h_q  <= bits_h_d;
      bits_w_q  <= bits_w_d;
    end
  end

  // Neighbour indexes and fractions from the finished quotients.
  logic [QIW-1:0] qi_h, qi_w;
  logic [SW1-1:0] lo_h, hi_h, lo_w, hi_w;

  assign qi_h = bits_h_q[QP-1:F];
  assign qi_w = bits_w_q[QP-1:F];
  assign lo_h = (qi_h > QIW'(sm1)) ? sm1 : SW1'(qi_h);
  assign lo_w = (qi_w > QIW'(sm1)) ? sm1 : SW1'(qi_w);
  assign hi_h = (lo_h == sm1) ? sm1 : SW1'(lo_h + SW1'(1));
  assign hi_w = (lo_w == sm1) ? sm1 : SW1'(lo_w + SW1'(1));

  // Stage 2: table access sequencer, one memory access per cycle.
  logic [1:0]              s2_kind_q, beat_q;
  logic [SW1-1:0]          s2_lo_h_q, s2_hi_h_q, s2_lo_w_q, s2_hi_w_q;
  logic [ber_pkg::DIM_W-1:0] s2_dim_q;
  logic signed [WORDW-1:0] s2_word_q;
  logic                    s2_ok_q;
  logic [F-1:0]            fh_q, fw_q;

  assign s2_last = s2_valid_q && ((s2_kind_q != ber_pkg::KIND_SAMPLE) || (beat_q == 2'd3));
  assign s2_open = !s2_valid_q || s2_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s2_kind_q  <= ber_pkg::KIND_LOAD;
      beat_q     <= '0;
    end else if (s2_open) begin
      s2_valid_q <= handoff;
      beat_q     <= '0;
      if (handoff) begin
        s2_kind_q <= s1_kind_q;
      end
    end else begin
      beat_q <= beat_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (handoff) begin
      s2_dim_q  <= s1_dim_q;
      s2_word_q <= s1_word_q;
      s2_ok_q   <= s1_ok_q;
      fh_q      <= bits_h_q[F-1:0];
      fw_q      <= bits_w_q[F-1:0];
      if (s1_kind_q == ber_pkg::KIND_LOAD) begin
        s2_lo_h_q <= SW1'(s1_row_q);
        s2_hi_h_q <= SW1'(s1_row_q);
        s2_lo_w_q <= SW1'(s1_col_q);
        s2_hi_w_q <= SW1'(s1_col_q);
      end else begin
        s2_lo_h_q <= lo_h;
        s2_hi_h_q <= hi_h;
        s2_lo_w_q <= lo_w;
        s2_hi_w_q <= hi_w;
      end
    end
  end

  logic [SW1-1:0]          mem_r, mem_c;
  logic [AW-1:0]           mem_addr;
  logic                    mem_we, mem_re;
  logic signed [WORDW-1:0] table_q [DEPTH];
  logic signed [WORDW-1:0] rdata_q;

  assign mem_r    = beat_q[1] ? s2_hi_h_q : s2_lo_h_q;
  assign mem_c    = beat_q[0] ? s2_hi_w_q : s2_lo_w_q;
  assign mem_addr = AW'((32'(mem_r) * SIDE_LIMIT + 32'(mem_c)) * DIM + 32'(s2_dim_q));
  assign mem_we   = s2_valid_q && (s2_kind_q == ber_pkg::KIND_LOAD) && s2_ok_q;
  assign mem_re   = s2_valid_q && (s2_kind_q == ber_pkg::KIND_SAMPLE);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_q[mem_addr] <= s2_word_q;
    end else if (mem_re) begin
      rdata_q <= table_q[mem_addr];
    end
  end

  // Weighting pipeline: corner weight, weighted element, running sum.
  logic [WW-1:0]         wa, wb;
  logic [2*WW-1:0]       wgt_q;
  logic                  t1_valid_q, t1_first_q, t1_last_q, t1_oor_q;
  logic signed [PRW-1:0] prod_q;
  logic                  t2_valid_q, t2_first_q, t2_last_q, t2_oor_q;
  logic signed [PRW-1:0] acc_q, acc_rnd;
  logic                  fin_q, fin_oor_q;
  logic signed [SATW-1:0] acc_sh;
  ber_pkg::result_t      res;

  assign wa = beat_q[1] ? WW'(fh_q) : WW'((WW'(1) << F) - WW'(fh_q));
  assign wb = beat_q[0] ? WW'(fw_q) : WW'((WW'(1) << F) - WW'(fw_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_valid_q <= 1'b0;
      t2_valid_q <= 1'b0;
      fin_q      <= 1'b0;
    end else begin
      t1_valid_q <= s2_valid_q && (s2_kind_q != ber_pkg::KIND_LOAD);
      t2_valid_q <= t1_valid_q;
      fin_q      <= t2_valid_q && t2_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    wgt_q      <= (2*WW)'(wa) * (2*WW)'(wb);
    t1_first_q <= (beat_q == 2'd0);
    t1_last_q  <= s2_last;
    t1_oor_q   <= (s2_kind_q == ber_pkg::KIND_OOR);
    if (t1_oor_q) begin
      prod_q <= '0;
    end else begin
      prod_q <= PRW'($signed({1'b0, wgt_q})) * PRW'(rdata_q);
    end
    t2_first_q <= t1_first_q;
    t2_last_q  <= t1_last_q;
    t2_oor_q   <= t1_oor_q;
    if (t2_valid_q) begin
      acc_q     <= (t2_first_q ? '0 : acc_q) + prod_q;
      fin_oor_q <= t2_oor_q;
    end
  end

  always_comb begin
    acc_rnd = acc_q + (PRW'(1) <<< (2 * F - 1));
    acc_sh  = SATW'(acc_rnd >>> (2 * F));
    if (acc_sh > SATW'(32767)) begin
      res.sample = 16'sh7FFF;
    end else if (acc_sh < -SATW'(32768)) begin
      res.sample = -16'sh8000;
    end else begin
      res.sample = WORDW'(acc_sh);
    end
    res.oor = fin_oor_q;
    if (fin_oor_q) begin
      res.sample = '0;
    end
  end

  // Result queue and outstanding-sample count.
  ber_pkg::result_t res_q [RD];
  logic [RPW-1:0]   wptr_q, rptr_q;
  logic [RCW-1:0]   count_q;
  logic             pop;

  assign out_valid_o    = (count_q != '0);
  assign sample_o       = res_q[rptr_q].sample;
  assign out_of_range_o = res_q[rptr_q].oor;
  assign pop            = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (fin_q) begin
      res_q[wptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q   <= '0;
      rptr_q   <= '0;
      count_q  <= '0;
      credit_q <= '0;
    end else begin
      if (fin_q) begin
        wptr_q <= wptr_q + RPW'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + RPW'(1);
      end
      count_q  <= count_q + RCW'(fin_q) - RCW'(pop);
      credit_q <= credit_q + RCW'(handoff && (s1_kind_q != ber_pkg::KIND_LOAD)) - RCW'(pop);
    end
  end

endmodule
